// ===== rtl/mewu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mewu_pkg: shared types and constants of the execute and write-back unit
// Operation codes, register numbers and the descriptor type.
// ----------------------------------------------------------------------------
package mewu_pkg;

	localparam logic [5:0] OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_ADDIU = 6'd2, OP_SUB = 6'd3,
		OP_SUBU = 6'd4, OP_MUL = 6'd5, OP_MULU = 6'd6, OP_DIVU = 6'd7, OP_DIV = 6'd8,
		OP_XOR = 6'd9, OP_XORU = 6'd10, OP_NEG = 6'd11, OP_NEGU = 6'd12, OP_REM = 6'd13,
		OP_REMU = 6'd14, OP_LI = 6'd15, OP_SEQ = 6'd16, OP_SGE = 6'd17, OP_SGT = 6'd18,
		OP_SLE = 6'd19, OP_SLT = 6'd20, OP_SNE = 6'd21, OP_B = 6'd22, OP_BEQ = 6'd23,
		OP_BNE = 6'd24, OP_BGE = 6'd25, OP_BLE = 6'd26, OP_BGT = 6'd27, OP_BLT = 6'd28,
		OP_BEQZ = 6'd29, OP_BNEZ = 6'd30, OP_BGEZ = 6'd31, OP_BLEZ = 6'd32,
		OP_BGTZ = 6'd33, OP_BLTZ = 6'd34, OP_J = 6'd35, OP_JR = 6'd36, OP_JAL = 6'd37,
		OP_JALR = 6'd38, OP_LA = 6'd39, OP_LB = 6'd40, OP_LH = 6'd41, OP_LW = 6'd42,
		OP_SB = 6'd43, OP_SH = 6'd44, OP_SW = 6'd45, OP_MOVE = 6'd46, OP_MFHI = 6'd47,
		OP_MFLO = 6'd48;

	localparam logic [5:0] REG_RA = 6'd31, REG_LO = 6'd32, REG_HI = 6'd33, REG_PC = 6'd34;

	localparam logic [1:0] ACT_NONE = 2'd0, ACT_REG = 2'd1, ACT_LOAD = 2'd2,
		ACT_STORE = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  write_count;
		logic [5:0]  write_reg_a;
		logic [31:0] write_value_a;
		logic [5:0]  write_reg_b;
		logic [31:0] write_value_b;
		logic [31:0] mem_address;
		logic [2:0]  mem_size;
		logic [31:0] mem_store_data;
		logic [4:0]  load_dest_reg;
		logic        div_by_zero;
	} desc_t;

	// Where the value of each write comes from once the long units finish
	typedef enum logic [2:0] {
		SRC_FIXED, SRC_PROD_LO, SRC_PROD_HI, SRC_QUOT, SRC_REM
	} src_t;

endpackage
`default_nettype wire

// ===== rtl/mewu_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mewu_divider: pipelined 32-bit divider
// Restoring division of magnitudes, one stage per bit, sign fix at the end.
// Zero divisor gives zero quotient and remainder.
// ----------------------------------------------------------------------------
module mewu_divider import mewu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        advance,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	input  wire logic        sgn,
	output logic      [31:0] quotient,
	output logic      [31:0] remainder
);

	localparam int Steps = 32;

	logic [31:0] rem_q [Steps+1];
	logic [31:0] quo_q [Steps+1];
	logic [31:0] dvs_q [Steps+1];
	logic        negq_q [Steps+1];
	logic        negr_q [Steps+1];
	logic        zero_q [Steps+1];

	logic        neg_a, neg_b;

	// Take magnitudes at entry
	always_comb begin
		neg_a = sgn & dividend[31];
		neg_b = sgn & divisor[31];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rem_q[0]  <= 32'd0;
			quo_q[0]  <= neg_a ? (32'd0 - dividend) : dividend;
			dvs_q[0]  <= neg_b ? (32'd0 - divisor) : divisor;
			negq_q[0] <= neg_a ^ neg_b;
			negr_q[0] <= neg_a;
			zero_q[0] <= (divisor == 32'd0);
		end
	end

	// One quotient bit per stage
	for (genvar i = 0; i < Steps; i++) begin : g_step
		logic [32:0] trial;
		logic [31:0] shifted;
		always_comb begin
			shifted = {rem_q[i][30:0], quo_q[i][31]};
			trial   = {rem_q[i][31], shifted} - {1'b0, dvs_q[i]};
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				rem_q[i+1]  <= trial[32] ? shifted : trial[31:0];
				quo_q[i+1]  <= {quo_q[i][30:0], ~trial[32]};
				dvs_q[i+1]  <= dvs_q[i];
				negq_q[i+1] <= negq_q[i];
				negr_q[i+1] <= negr_q[i];
				zero_q[i+1] <= zero_q[i];
			end
		end
	end

	// Apply signs, force zero divisor to zero
	always_comb begin
		quotient  = zero_q[Steps] ? 32'd0 :
			(negq_q[Steps] ? (32'd0 - quo_q[Steps]) : quo_q[Steps]);
		remainder = zero_q[Steps] ? 32'd0 :
			(negr_q[Steps] ? (32'd0 - rem_q[Steps]) : rem_q[Steps]);
	end

endmodule
`default_nettype wire

// ===== rtl/mewu_multiplier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mewu_multiplier: two-stage 32 x 32 multiplier
// Sign-extended 33-bit operands registered, then the product registered; low 64 bits out.
// ----------------------------------------------------------------------------
module mewu_multiplier import mewu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        advance,
	input  wire logic [31:0] x,
	input  wire logic [31:0] y,
	input  wire logic        sgn,
	output logic      [63:0] product
);

	logic signed [32:0] x_s1, y_s1;
	logic signed [65:0] p_s2;

	// Register operands, then the product
	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1 <= {sgn & x[31], x};
			y_s1 <= {sgn & y[31], y};
			p_s2 <= x_s1 * y_s1;
		end
	end

	assign product = p_s2[63:0];

endmodule
`default_nettype wire

// ===== rtl/mips_execute_writeback_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_execute_writeback_unit: MIPS32 execute and write-back stage
// Decodes one instruction into a write-back descriptor per cycle while the output does not stall.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | role
//  in       | in_valid, in_stall, cmd .. three_operand  | decoded instruction
//  out      | out_valid, out_stall, action .. div_by_zero | write-back item
//
// The result item passes through the divider's entry stage, one stage per
// quotient bit, then the merge stage; the divider sets the depth of the pipe.
// One item is accepted per cycle while the output does not stall.
// Reset clears the valid bits only. A stall at the output freezes the whole
// pipe and holds in_stall high; while the last stage is empty nothing stalls.
// ----------------------------------------------------------------------------
module mips_execute_writeback_unit import mewu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [5:0]  cmd,
	input  wire logic signed [31:0] operand_a,
	input  wire logic signed [31:0] operand_b,
	input  wire logic signed [31:0] operand_c,
	input  wire logic [4:0]  dest_reg,
	input  wire logic        three_operand,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       action,
	output logic [1:0]       write_count,
	output logic [5:0]       write_reg_a,
	output logic [31:0]      write_value_a,
	output logic [5:0]       write_reg_b,
	output logic [31:0]      write_value_b,
	output logic [31:0]      mem_address,
	output logic [2:0]       mem_size,
	output logic [31:0]      mem_store_data,
	output logic [4:0]       load_dest_reg,
	output logic             div_by_zero
);

	localparam int Depth = 33;

	logic        advance;
	desc_t       d_c;
	src_t        srca_c, srcb_c;
	logic [31:0] mx_c, my_c, dx_c, dy_c;
	logic        msgn_c, dsgn_c, dz_c;
	logic        take;
	logic signed [31:0] a, b, c;

	logic        v_q [Depth];
	desc_t       d_q [Depth];
	src_t        sa_q [Depth];
	src_t        sb_q [Depth];
	logic [63:0] prod;
	logic [63:0] prod_q [Depth];
	logic [31:0] quot, remd;
	desc_t       fin_c;
	desc_t       fin_s;
	logic        fin_v_s;

	assign a = operand_a;
	assign b = operand_b;
	assign c = operand_c;

	// Advance whenever the output slot is free or being taken
	assign advance  = !(fin_v_s && out_stall);
	assign in_stall = !advance;

	// Decode: fixed fields and unit operands
	always_comb begin
		d_c = '0;
		srca_c = SRC_FIXED;
		srcb_c = SRC_FIXED;
		mx_c = operand_b; my_c = operand_c; msgn_c = 1'b0;
		dx_c = operand_b; dy_c = operand_c; dsgn_c = 1'b0;
		dz_c = 1'b0;
		take = 1'b0;
		case (cmd)
			OP_ADD, OP_ADDU, OP_ADDIU, OP_LA: begin
				d_c.action = ACT_REG; d_c.write_count = 2'd1;
				d_c.write_reg_a = {1'b0, dest_reg};
				d_c.write_value_a = operand_b + operand_c;
			end
			OP_SUB, OP_SUBU: begin
				d_c.action = ACT_REG; d_c.write_count = 2'd1;
				d_c.write_reg_a = {1'b0, dest_reg};
				d_c.write_value_a = operand_b - operand_c;
			end
			OP_MUL, OP_MULU: begin
				d_c.action = ACT_REG;
				if (three_operand) begin
					d_c.write_count = 2'd1;
					d_c.write_reg_a = {1'b0, dest_reg};
					srca_c = SRC_PROD_LO;
				end else begin
					d_c.write_count = 2'd2;
					d_c.write_reg_a = REG_HI; d_c.write_reg_b = REG_LO;
					srca_c = SRC_PROD_HI; srcb_c = SRC_PROD_LO;
					mx_c = operand_a; my_c = operand_b;
					msgn_c = (cmd == OP_MUL);
				end
			end
			OP_DIVU, OP_DIV: begin
				d_c.action = ACT_REG;
				dsgn_c = (cmd == OP_DIV);
				if (three_operand) begin
					d_c.write_count = 2'd1;
					d_c.write_reg_a = {1'b0, dest_reg};
					srca_c = SRC_QUOT;
				end else begin
					d_c.write_count = 2'd2;
					d_c.write_reg_a = REG_HI; d_c.write_reg_b = REG_LO;
					srca_c = SRC_REM; srcb_c = SRC_QUOT;
					dx_c = operand_a; dy_c = operand_b;
				end
				dz_c = 1'b1;
			end
			OP_XOR, OP_XORU: begin
				d_c.action = ACT_REG; d_c.write_count = 2'd1;
				d_c.write_reg_a = {1'b0, dest_reg};
				d_c.write_value_a = operand_b ^ operand_c;
			end
			OP_NEG, OP_NEGU: begin
				d_c.action = ACT_REG; d_c.write_count = 2'd1;
				d_c.write_reg_a = {1'b0, dest_reg};
				d_c.write_value_a = 32'd0 - operand_b;
			end
			OP_REM, OP_REMU: begin
				d_c.action = ACT_REG; d_c.write_count = 2'd1;
				d_c.write_reg_a = {1'b0, dest_reg};
				srca_c = SRC_REM;
				dsgn_c = (cmd == OP_REM);
				dz_c = 1'b1;
			end
			OP_LI, OP_MOVE, OP_MFHI, OP_MFLO: begin
				d_c.action = ACT_REG; d_c.write_count = 2'd1;
				d_c.write_reg_a = {1'b0, dest_reg};
				d_c.write_value_a = operand_b;
			end
			OP_SEQ, OP_SGE, OP_SGT, OP_SLE, OP_SLT, OP_SNE: begin
				d_c.action = ACT_REG; d_c.write_count = 2'd1;
				d_c.write_reg_a = {1'b0, dest_reg};
				case (cmd)
					OP_SEQ:  d_c.write_value_a = {31'd0, b == c};
					OP_SGE:  d_c.write_value_a = {31'd0, b >= c};
					OP_SGT:  d_c.write_value_a = {31'd0, b > c};
					OP_SLE:  d_c.write_value_a = {31'd0, b <= c};
					OP_SLT:  d_c.write_value_a = {31'd0, b < c};
					default: d_c.write_value_a = {31'd0, b != c};
				endcase
			end
			OP_B, OP_J: take = 1'b1;
			OP_BEQ:  take = (a == b);
			OP_BNE:  take = (a != b);
			OP_BGE:  take = (a >= b);
			OP_BLE:  take = (a <= b);
			OP_BGT:  take = (a > b);
			OP_BLT:  take = (a < b);
			OP_BEQZ: take = (a == 0);
			OP_BNEZ: take = (a != 0);
			OP_BGEZ: take = (a >= 0);
			OP_BLEZ: take = (a <= 0);
			OP_BGTZ: take = (a > 0);
			OP_BLTZ: take = (a < 0);
			OP_JR: begin
				d_c.action = ACT_REG; d_c.write_count = 2'd1;
				d_c.write_reg_a = REG_PC; d_c.write_value_a = operand_a;
			end
			OP_JAL, OP_JALR: begin
				d_c.action = ACT_REG; d_c.write_count = 2'd2;
				d_c.write_reg_a = REG_RA; d_c.write_value_a = operand_b;
				d_c.write_reg_b = REG_PC;
				d_c.write_value_b = (cmd == OP_JAL) ? operand_c : operand_a;
			end
			OP_LB, OP_LH, OP_LW: begin
				d_c.action = ACT_LOAD;
				d_c.mem_address = operand_c + operand_b;
				d_c.mem_size = (cmd == OP_LB) ? 3'd1 : ((cmd == OP_LH) ? 3'd2 : 3'd4);
				d_c.load_dest_reg = dest_reg;
			end
			OP_SB, OP_SH, OP_SW: begin
				d_c.action = ACT_STORE;
				d_c.mem_address = operand_c + operand_b;
				d_c.mem_size = (cmd == OP_SB) ? 3'd1 : ((cmd == OP_SH) ? 3'd2 : 3'd4);
				d_c.mem_store_data = operand_a;
			end
			default: ;
		endcase
		if (take) begin
			d_c.action = ACT_REG; d_c.write_count = 2'd1;
			d_c.write_reg_a = REG_PC; d_c.write_value_a = operand_c;
		end
		d_c.div_by_zero = dz_c && (dy_c == 32'd0);
	end

	mewu_multiplier u_mul (
		.clk(clk), .advance(advance), .x(mx_c), .y(my_c), .sgn(msgn_c), .product(prod)
	);

	mewu_divider u_div (
		.clk(clk), .advance(advance), .dividend(dx_c), .divisor(dy_c),
		.sgn(dsgn_c), .quotient(quot), .remainder(remd)
	);

	// Valid bits and descriptors travel alongside the units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Depth; i++) v_q[i] <= 1'b0;
		end else if (advance) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < Depth; i++) v_q[i] <= v_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			d_q[0] <= d_c; sa_q[0] <= srca_c; sb_q[0] <= srcb_c;
			prod_q[0] <= '0;
			for (int i = 1; i < Depth; i++) begin
				d_q[i] <= d_q[i-1]; sa_q[i] <= sa_q[i-1]; sb_q[i] <= sb_q[i-1];
				prod_q[i] <= (i == 2) ? prod : prod_q[i-1];
			end
		end
	end

	// Merge unit results into the final descriptor
	function automatic logic [31:0] pick(src_t s, logic [31:0] fixed, logic [63:0] p,
			logic [31:0] qq, logic [31:0] rr);
		case (s)
			SRC_PROD_LO: pick = p[31:0];
			SRC_PROD_HI: pick = p[63:32];
			SRC_QUOT:    pick = qq;
			SRC_REM:     pick = rr;
			default:     pick = fixed;
		endcase
	endfunction

	always_comb begin
		fin_c = d_q[Depth-1];
		fin_c.write_value_a = pick(sa_q[Depth-1], d_q[Depth-1].write_value_a,
			prod_q[Depth-1], quot, remd);
		fin_c.write_value_b = pick(sb_q[Depth-1], d_q[Depth-1].write_value_b,
			prod_q[Depth-1], quot, remd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_v_s <= 1'b0;
		else if (advance) fin_v_s <= v_q[Depth-1];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fin_s <= fin_c;
		end
	end

	assign out_valid      = fin_v_s;
	assign action         = fin_s.action;
	assign write_count    = fin_s.write_count;
	assign write_reg_a    = fin_s.write_reg_a;
	assign write_value_a  = fin_s.write_value_a;
	assign write_reg_b    = fin_s.write_reg_b;
	assign write_value_b  = fin_s.write_value_b;
	assign mem_address    = fin_s.mem_address;
	assign mem_size       = fin_s.mem_size;
	assign mem_store_data = fin_s.mem_store_data;
	assign load_dest_reg  = fin_s.load_dest_reg;
	assign div_by_zero    = fin_s.div_by_zero;

endmodule
`default_nettype wire
